// ===== hdl/rgb2ycc_pkg.sv =====
`default_nettype none

package rgb2ycc_pkg;

  localparam int unsigned PixelCount = 4;

  localparam logic [17:0] LumaBias   = 18'd16384;
  localparam logic [17:0] ChromaBias = 18'd131072;

  localparam logic [9:0] CoefYR  = 10'd263;
  localparam logic [9:0] CoefYG  = 10'd516;
  localparam logic [9:0] CoefYB  = 10'd100;
  localparam logic [9:0] CoefCbR = 10'd152;
  localparam logic [9:0] CoefCbG = 10'd298;
  localparam logic [9:0] CoefCbB = 10'd450;
  localparam logic [9:0] CoefCrR = 10'd450;
  localparam logic [9:0] CoefCrG = 10'd377;
  localparam logic [9:0] CoefCrB = 10'd73;

  localparam logic [7:0] LumaLow    = 8'd16;
  localparam logic [7:0] LumaHigh   = 8'd235;
  localparam logic [7:0] ChromaLow  = 8'd16;
  localparam logic [7:0] ChromaHigh = 8'd240;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  luma;
    logic [17:0] cb_q10;
    logic [17:0] cr_q10;
  } pixel_ycc_t;

  function automatic logic [7:0] clamp8(input logic [7:0] value,
                                        input logic [7:0] low,
                                        input logic [7:0] high);
    logic [7:0] res;
    if (value < low) begin
      res = low;
    end else if (value > high) begin
      res = high;
    end else begin
      res = value;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rgb_block_to_ycbcr_420.sv =====
// Channel   | Signals                                   | Handshake
// ----------+-------------------------------------------+-------------------------
// Input     | red/green/blue_{top,bottom}_{left,right}  | start high, busy low
// Result    | luma_*, chroma_blue, chroma_red           | done high for one cycle
//
// One transaction is accepted every clock cycle; busy is always low.
// The result and done are driven from the clock edge after the accepting edge;
// the receiver takes them while done is high.
// The path from input to result runs through the input register and the result register.
// Reset clears the valid flags of both stages; payload registers are not reset.
// The receiver cannot stall, so no transaction is ever held back.
`default_nettype none

module rgb_block_to_ycbcr_420 (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output var  logic       busy,
  input  wire logic [7:0] red_top_left,
  input  wire logic [7:0] green_top_left,
  input  wire logic [7:0] blue_top_left,
  input  wire logic [7:0] red_top_right,
  input  wire logic [7:0] green_top_right,
  input  wire logic [7:0] blue_top_right,
  input  wire logic [7:0] red_bottom_left,
  input  wire logic [7:0] green_bottom_left,
  input  wire logic [7:0] blue_bottom_left,
  input  wire logic [7:0] red_bottom_right,
  input  wire logic [7:0] green_bottom_right,
  input  wire logic [7:0] blue_bottom_right,
  output var  logic       done,
  output var  logic [7:0] luma_top_left,
  output var  logic [7:0] luma_top_right,
  output var  logic [7:0] luma_bottom_left,
  output var  logic [7:0] luma_bottom_right,
  output var  logic [7:0] chroma_blue,
  output var  logic [7:0] chroma_red
);

  rgb2ycc_pkg::pixel_t     pixels [rgb2ycc_pkg::PixelCount];
  rgb2ycc_pkg::pixel_ycc_t yccs   [rgb2ycc_pkg::PixelCount];
  logic                    pixels_valid;
  logic [19:0]             cb_sum;
  logic [19:0]             cr_sum;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_valid <= 1'b0;
      done         <= 1'b0;
    end else begin
      pixels_valid <= start && !busy;
      done         <= pixels_valid;
    end
  end

  always_ff @(posedge clk) begin
    pixels[0] <= '{red: red_top_left, green: green_top_left, blue: blue_top_left};
    pixels[1] <= '{red: red_top_right, green: green_top_right, blue: blue_top_right};
    pixels[2] <= '{red: red_bottom_left, green: green_bottom_left, blue: blue_bottom_left};
    pixels[3] <= '{red: red_bottom_right, green: green_bottom_right,
                   blue: blue_bottom_right};
  end

  for (genvar i = 0; i < rgb2ycc_pkg::PixelCount; i++) begin : g_pixel
    rgb2ycc_pixel u_pixel (
      .pixel (pixels[i]),
      .ycc   (yccs[i])
    );
  end

  assign cb_sum = 20'(yccs[0].cb_q10) + 20'(yccs[1].cb_q10)
                + 20'(yccs[2].cb_q10) + 20'(yccs[3].cb_q10);
  assign cr_sum = 20'(yccs[0].cr_q10) + 20'(yccs[1].cr_q10)
                + 20'(yccs[2].cr_q10) + 20'(yccs[3].cr_q10);

  always_ff @(posedge clk) begin
    luma_top_left     <= yccs[0].luma;
    luma_top_right    <= yccs[1].luma;
    luma_bottom_left  <= yccs[2].luma;
    luma_bottom_right <= yccs[3].luma;
    chroma_blue <= rgb2ycc_pkg::clamp8(cb_sum[19:12], rgb2ycc_pkg::ChromaLow,
                                       rgb2ycc_pkg::ChromaHigh);
    chroma_red  <= rgb2ycc_pkg::clamp8(cr_sum[19:12], rgb2ycc_pkg::ChromaLow,
                                       rgb2ycc_pkg::ChromaHigh);
  end

endmodule

`default_nettype wire

// ===== hdl/rgb2ycc_pixel.sv =====
`default_nettype none

module rgb2ycc_pixel (
  input  var rgb2ycc_pkg::pixel_t     pixel,
  output var rgb2ycc_pkg::pixel_ycc_t ycc
);

  logic [17:0] red;
  logic [17:0] green;
  logic [17:0] blue;
  logic [17:0] luma_acc;
  logic [17:0] cb_pos;
  logic [17:0] cb_neg;
  logic [17:0] cr_pos;
  logic [17:0] cr_neg;

  assign red   = 18'(pixel.red);
  assign green = 18'(pixel.green);
  assign blue  = 18'(pixel.blue);

  assign luma_acc = rgb2ycc_pkg::LumaBias
                  + 18'(rgb2ycc_pkg::CoefYR) * red
                  + 18'(rgb2ycc_pkg::CoefYG) * green
                  + 18'(rgb2ycc_pkg::CoefYB) * blue;

  assign cb_pos = rgb2ycc_pkg::ChromaBias + 18'(rgb2ycc_pkg::CoefCbB) * blue;
  assign cb_neg = 18'(rgb2ycc_pkg::CoefCbR) * red + 18'(rgb2ycc_pkg::CoefCbG) * green;
  assign cr_pos = rgb2ycc_pkg::ChromaBias + 18'(rgb2ycc_pkg::CoefCrR) * red;
  assign cr_neg = 18'(rgb2ycc_pkg::CoefCrG) * green + 18'(rgb2ycc_pkg::CoefCrB) * blue;

  assign ycc.luma   = rgb2ycc_pkg::clamp8(luma_acc[17:10], rgb2ycc_pkg::LumaLow,
                                          rgb2ycc_pkg::LumaHigh);
  assign ycc.cb_q10 = cb_pos - cb_neg;
  assign ycc.cr_q10 = cr_pos - cr_neg;

endmodule

`default_nettype wire
